>>> rtl/epp_pkg.sv
// ============================================================================
// epp_pkg - envelope peak picker package
// Default widths, register defaults, register indexes and result codes.
// ============================================================================
package epp_pkg;

    // default field widths
    localparam int INDEX_BITS_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_START    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEARCH_END      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPACING_WINDOW  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPLACE_WINDOW  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FALLBACK_ENABLE = 3'd5;

    // register reset values
    localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RST      = 16'd768;
    localparam logic [CFG_DATA_BITS-1:0] SEARCH_START_RST   = 16'd1;
    localparam logic [CFG_DATA_BITS-1:0] SEARCH_END_RST     = 16'd65534;
    localparam logic [CFG_DATA_BITS-1:0] SPACING_WINDOW_RST = 16'd20;
    localparam logic [CFG_DATA_BITS-1:0] REPLACE_WINDOW_RST = 16'd10;

    // pick counter
    localparam int COUNT_BITS = 16;

    // candidate skip after any candidate
    localparam logic [1:0] SKIP_COUNT = 2'd2;

    // result kinds
    localparam logic KIND_PICK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // result queue: one item can cause up to three results
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

endpackage

>>> rtl/envelope_peak_picker.sv
// ============================================================================
// envelope_peak_picker - threshold peak picking with minimum spacing
// Examines each envelope sample against its neighbors, holds and refines
// picks, emits final picks and a per-trace summary into a result queue.
// ============================================================================
// Results of a sample are written into the queue registers at its transfer.
// Throughput: one sample per cycle; each result leaves the queue in its own
// cycle, and in_ready needs three free queue slots (queue depth 4).
// Reset: rst_n clears registers to defaults and all trace state; the queue
// starts empty. Trace state clears again after each end_of_trace.
module envelope_peak_picker #(
    parameter int INDEX_BITS  = epp_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = epp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write,
    input  logic [epp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [epp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [SAMPLE_BITS-1:0]             ee_sample,
    input  logic                               end_of_trace,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               result_kind,
    output logic [INDEX_BITS-1:0]              pick_index,
    output logic [SAMPLE_BITS-1:0]             pick_value,
    output logic [epp_pkg::COUNT_BITS-1:0]     pick_total,
    output logic                               used_fallback,
    output logic                               last_of_run
);

    localparam int CW    = (INDEX_BITS > epp_pkg::CFG_DATA_BITS) ?
                           INDEX_BITS : epp_pkg::CFG_DATA_BITS;
    localparam int TW    = (SAMPLE_BITS > epp_pkg::CFG_DATA_BITS) ?
                           SAMPLE_BITS : epp_pkg::CFG_DATA_BITS;
    localparam int QD    = epp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(QD);
    localparam int QCW   = $clog2(QD + 1);
    localparam int CB    = epp_pkg::COUNT_BITS;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
    localparam logic [CB-1:0]         CNT_MAX = {CB{1'b1}};
    localparam logic [QCW-1:0]        READY_LIMIT = QCW'(QD - epp_pkg::MAX_RESULTS);

    typedef struct packed {
        logic                   kind;
        logic [INDEX_BITS-1:0]  idx;
        logic [SAMPLE_BITS-1:0] val;
        logic [CB-1:0]          total;
        logic                   fallback;
        logic                   last;
    } result_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [epp_pkg::CFG_DATA_BITS-1:0] threshold_reg;
    logic [epp_pkg::CFG_DATA_BITS-1:0] search_start_reg;
    logic [epp_pkg::CFG_DATA_BITS-1:0] search_end_reg;
    logic [epp_pkg::CFG_DATA_BITS-1:0] spacing_window_reg;
    logic [epp_pkg::CFG_DATA_BITS-1:0] replace_window_reg;
    logic                              fallback_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg       <= epp_pkg::THRESHOLD_RST;
            search_start_reg    <= epp_pkg::SEARCH_START_RST;
            search_end_reg      <= epp_pkg::SEARCH_END_RST;
            spacing_window_reg  <= epp_pkg::SPACING_WINDOW_RST;
            replace_window_reg  <= epp_pkg::REPLACE_WINDOW_RST;
            fallback_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                epp_pkg::REG_THRESHOLD:       threshold_reg       <= cfg_data;
                epp_pkg::REG_SEARCH_START:    search_start_reg    <= cfg_data;
                epp_pkg::REG_SEARCH_END:      search_end_reg      <= cfg_data;
                epp_pkg::REG_SPACING_WINDOW:  spacing_window_reg  <= cfg_data;
                epp_pkg::REG_REPLACE_WINDOW:  replace_window_reg  <= cfg_data;
                epp_pkg::REG_FALLBACK_ENABLE: fallback_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // trace state
    // ------------------------------------------------------------------
    logic [INDEX_BITS-1:0]  pos_reg,        pos_next;
    logic [SAMPLE_BITS-1:0] earlier_reg,    earlier_next;
    logic [SAMPLE_BITS-1:0] middle_reg,     middle_next;
    logic [1:0]             skip_reg,       skip_next;
    logic                   held_valid_reg, held_valid_next;
    logic [INDEX_BITS-1:0]  held_index_reg, held_index_next;
    logic [SAMPLE_BITS-1:0] held_value_reg, held_value_next;
    logic [CB-1:0]          count_reg,      count_next;
    logic [SAMPLE_BITS-1:0] best_value_reg, best_value_next;
    logic [INDEX_BITS-1:0]  best_index_reg, best_index_next;

    logic in_xfer;
    logic out_xfer;

    // per-sample detection terms
    logic [INDEX_BITS-1:0]  m_idx;
    logic [INDEX_BITS-1:0]  pick_gap;
    logic                   examine;
    logic                   in_win;
    logic                   new_pick;
    logic                   emit_old;
    logic                   below_half;
    result_t                res_old;
    result_t                res_held;
    result_t                res_sum;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign m_idx    = pos_reg - INDEX_BITS'(1);
    assign pick_gap = m_idx - held_index_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        earlier_next    = earlier_reg;
        middle_next     = middle_reg;
        skip_next       = skip_reg;
        held_valid_next = held_valid_reg;
        held_index_next = held_index_reg;
        held_value_next = held_value_reg;
        count_next      = count_reg;
        best_value_next = best_value_reg;
        best_index_next = best_index_reg;
        new_pick        = 1'b0;

        // sample m = pos-1 is examined when m+1 arrives, until pos saturates
        examine    = (pos_reg != IDX_MAX) && (pos_reg != '0);
        in_win     = examine && (m_idx != '0) &&
                     (CW'(m_idx) >= CW'(search_start_reg)) &&
                     (CW'(m_idx) <= CW'(search_end_reg));
        below_half = {middle_reg, 1'b0} < {1'b0, held_value_reg};

        if (pos_reg != IDX_MAX)
        begin
            // window maximum for fallback
            if (in_win && (middle_reg > best_value_reg))
            begin
                best_value_next = middle_reg;
                best_index_next = m_idx;
            end

            if (examine && (skip_reg != 2'd0))
            begin
                skip_next = skip_reg - 2'd1;
            end
            else if (in_win && (TW'(middle_reg) > TW'(threshold_reg)) &&
                     (earlier_reg <= middle_reg) && (ee_sample <= middle_reg))
            begin
                new_pick = 1'b1;
                // near the held pick: replace, drop if below half, else keep
                if (held_valid_reg && (CW'(pick_gap) < CW'(spacing_window_reg)))
                begin
                    if ((CW'(pick_gap) < CW'(replace_window_reg)) &&
                        (middle_reg > held_value_reg))
                    begin
                        held_index_next = m_idx;
                        held_value_next = middle_reg;
                        new_pick        = 1'b0;
                    end
                    else if (below_half)
                    begin
                        new_pick = 1'b0;
                    end
                end
                if (new_pick)
                begin
                    held_valid_next = 1'b1;
                    held_index_next = m_idx;
                    held_value_next = middle_reg;
                    if (count_reg != CNT_MAX)
                        count_next = count_reg + CB'(1);
                end
                skip_next = epp_pkg::SKIP_COUNT;
            end

            earlier_next = middle_reg;
            middle_next  = ee_sample;
            pos_next     = pos_reg + INDEX_BITS'(1);
        end

        emit_old = new_pick && held_valid_reg;

        // results this sample can cause, in order
        res_old.kind     = epp_pkg::KIND_PICK;
        res_old.idx      = held_index_reg;
        res_old.val      = held_value_reg;
        res_old.total    = '0;
        res_old.fallback = 1'b0;
        res_old.last     = !end_of_trace;

        res_held.kind     = epp_pkg::KIND_PICK;
        res_held.idx      = held_index_next;
        res_held.val      = held_value_next;
        res_held.total    = '0;
        res_held.fallback = 1'b0;
        res_held.last     = 1'b0;

        res_sum.kind = epp_pkg::KIND_SUMMARY;
        res_sum.last = 1'b1;
        if ((count_next == '0) && fallback_enable_reg)
        begin
            res_sum.idx      = best_index_next;
            res_sum.val      = best_value_next;
            res_sum.total    = CB'(1);
            res_sum.fallback = 1'b1;
        end
        else
        begin
            res_sum.idx      = '0;
            res_sum.val      = '0;
            res_sum.total    = count_next;
            res_sum.fallback = 1'b0;
        end

        // trace end clears all trace state
        if (end_of_trace)
        begin
            pos_next        = '0;
            earlier_next    = '0;
            middle_next     = '0;
            skip_next       = 2'd0;
            held_valid_next = 1'b0;
            held_index_next = '0;
            held_value_next = '0;
            count_next      = '0;
            best_value_next = '0;
            best_index_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            earlier_reg    <= '0;
            middle_reg     <= '0;
            skip_reg       <= 2'd0;
            held_valid_reg <= 1'b0;
            held_index_reg <= '0;
            held_value_reg <= '0;
            count_reg      <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
        end
        else if (in_xfer)
        begin
            pos_reg        <= pos_next;
            earlier_reg    <= earlier_next;
            middle_reg     <= middle_next;
            skip_reg       <= skip_next;
            held_valid_reg <= held_valid_next;
            held_index_reg <= held_index_next;
            held_value_reg <= held_value_next;
            count_reg      <= count_next;
            best_value_reg <= best_value_next;
            best_index_reg <= best_index_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue (power-of-two depth, pointers wrap naturally)
    // ------------------------------------------------------------------
    result_t           queue_reg [QD];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]    fill_reg,   fill_next;
    logic [1:0]        push_count;
    logic              push_held;
    logic              push_sum;
    logic [AW-1:0]     ptr_a;
    logic [AW-1:0]     ptr_b;
    logic [AW-1:0]     ptr_c;

    // a pick is held at trace end if one was held or this sample made one
    assign push_held = in_xfer && end_of_trace && (held_valid_reg || new_pick);
    assign push_sum  = in_xfer && end_of_trace;
    assign ptr_a     = wr_ptr_reg;
    assign ptr_b     = ptr_a + AW'(in_xfer && emit_old);
    assign ptr_c     = ptr_b + AW'(push_held);
    assign push_count = 2'(in_xfer && emit_old) + 2'(push_held) + 2'(push_sum);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_count);
        rd_ptr_next = rd_ptr_reg + AW'(out_xfer);
        fill_next   = fill_reg + QCW'(push_count) - QCW'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit_old)
            queue_reg[ptr_a] <= res_old;
        if (push_held)
            queue_reg[ptr_b] <= res_held;
        if (push_sum)
            queue_reg[ptr_c] <= res_sum;
    end

    // ------------------------------------------------------------------
    // handshake and output drive
    // ------------------------------------------------------------------
    assign in_ready  = (fill_reg <= READY_LIMIT);
    assign out_valid = (fill_reg != '0);

    assign result_kind   = queue_reg[rd_ptr_reg].kind;
    assign pick_index    = queue_reg[rd_ptr_reg].idx;
    assign pick_value    = queue_reg[rd_ptr_reg].val;
    assign pick_total    = queue_reg[rd_ptr_reg].total;
    assign used_fallback = queue_reg[rd_ptr_reg].fallback;
    assign last_of_run   = queue_reg[rd_ptr_reg].last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QCW'(QD))
        else $error("result queue overflow");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= epp_pkg::SKIP_COUNT)
        else $error("skip counter out of range");

    a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (count_reg != '0))
        else $error("held pick without pick count");

    a_trace_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && end_of_trace) |=> ((pos_reg == '0) && !held_valid_reg && out_valid))
        else $error("trace state not cleared after trace end");

endmodule

>>> sim/envelope_peak_picker_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// envelope_peak_picker_tb - testbench for the envelope peak picker
// Streams envelope traces through the sample channel and checks every final
// pick and trace summary against a cycle-free predictor kept in the bench.
// Covers the pick/replace/drop rules, the search window, the fallback,
// random settings and random traffic with sender gaps and receiver stalls.
// ============================================================================
module envelope_peak_picker_tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // one expected or observed result transfer
    typedef struct packed {
        logic        kind;
        logic [15:0] at_index;
        logic [15:0] level;
        logic [15:0] total;
        logic        fallback;
        logic        last;
    } pick_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // block inputs, known from time zero
    logic                               cfg_write    = 1'b0;
    logic [epp_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [epp_pkg::CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                               in_valid     = 1'b0;
    logic [15:0]                        ee_sample    = '0;
    logic                               end_of_trace = 1'b0;
    logic                               out_ready    = 1'b0;

    // block outputs
    logic        in_ready;
    logic        out_valid;
    logic        result_kind;
    logic [15:0] pick_index;
    logic [15:0] pick_value;
    logic [15:0] pick_total;
    logic        used_fallback;
    logic        last_of_run;

    envelope_peak_picker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ee_sample    (ee_sample),
        .end_of_trace (end_of_trace),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .pick_index   (pick_index),
        .pick_value   (pick_value),
        .pick_total   (pick_total),
        .used_fallback(used_fallback),
        .last_of_run  (last_of_run)
    );

    // traffic shaping, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // run bookkeeping
    int unsigned cycle_count  = 0;
    int          n_errors     = 0;
    int          n_samples    = 0;
    int          n_traces     = 0;
    int          n_checked    = 0;
    int          n_settings   = 0;

    pick_result_t pending_results [$];

    // predictor copy of the registers
    logic [15:0] cfg_threshold;
    logic [15:0] cfg_search_start;
    logic [15:0] cfg_search_end;
    logic [15:0] cfg_spacing;
    logic [15:0] cfg_replace;
    logic        cfg_fallback;

    // predictor copy of the trace state
    logic [15:0] trace_pos;
    logic [15:0] old_level;
    logic [15:0] mid_level;
    logic [1:0]  skip_left;
    logic        held_ok;
    logic [15:0] held_at;
    logic [15:0] held_level;
    logic [15:0] n_picks;
    logic [15:0] peak_level;
    logic [15:0] peak_at;

    // ------------------------------------------------------------------------
    // Peak picking predictor
    // ------------------------------------------------------------------------
    function automatic void clear_trace_state();
        trace_pos  = '0;
        old_level  = '0;
        mid_level  = '0;
        skip_left  = '0;
        held_ok    = 1'b0;
        held_at    = '0;
        held_level = '0;
        n_picks    = '0;
        peak_level = '0;
        peak_at    = '0;
    endfunction

    function automatic pick_result_t make_result(input logic kind, input logic [15:0] at_index,
                                                 input logic [15:0] level,
                                                 input logic [15:0] total,
                                                 input logic fallback);
        pick_result_t r;
        r.kind     = kind;
        r.at_index = at_index;
        r.level    = level;
        r.total    = total;
        r.fallback = fallback;
        r.last     = 1'b0;
        return r;
    endfunction

    // sample m is judged when sample m+1 arrives
    function automatic void predict_sample(input logic [15:0] x, input logic eot);
        pick_result_t made [$];
        logic [15:0]  m;
        logic [15:0]  v;
        logic [15:0]  gap;
        logic         in_win;
        logic         fresh;
        // a saturated position takes no part in detection
        if (trace_pos != 16'hFFFF) begin
            if (trace_pos != 16'd0) begin
                m      = trace_pos - 16'd1;
                v      = mid_level;
                in_win = (m >= 16'd1) && (m >= cfg_search_start) && (m <= cfg_search_end);
                if (in_win && v > peak_level) begin
                    peak_level = v;
                    peak_at    = m;
                end
                if (skip_left != 2'd0) begin
                    skip_left = skip_left - 2'd1;
                end
                else if (in_win && v > cfg_threshold && old_level <= v && x <= v) begin
                    fresh = 1'b1;
                    if (held_ok) begin
                        gap = m - held_at;
                        if (gap < cfg_spacing) begin
                            if (gap < cfg_replace && v > held_level) begin
                                held_at    = m;
                                held_level = v;
                                fresh      = 1'b0;
                            end
                            else if ({v, 1'b0} < {1'b0, held_level}) begin
                                fresh = 1'b0;
                            end
                        end
                    end
                    if (fresh) begin
                        if (held_ok)
                            made.push_back(make_result(epp_pkg::KIND_PICK, held_at,
                                                       held_level, 16'd0, 1'b0));
                        held_ok    = 1'b1;
                        held_at    = m;
                        held_level = v;
                        if (n_picks != 16'hFFFF)
                            n_picks = n_picks + 16'd1;
                    end
                    skip_left = epp_pkg::SKIP_COUNT;
                end
            end
            old_level = mid_level;
            mid_level = x;
            trace_pos = trace_pos + 16'd1;
        end

        // trace end: flush the held pick, then the summary
        if (eot) begin
            if (held_ok)
                made.push_back(make_result(epp_pkg::KIND_PICK, held_at, held_level,
                                           16'd0, 1'b0));
            if (n_picks == 16'd0 && cfg_fallback)
                made.push_back(make_result(epp_pkg::KIND_SUMMARY, peak_at, peak_level,
                                           16'd1, 1'b1));
            else
                made.push_back(make_result(epp_pkg::KIND_SUMMARY, 16'd0, 16'd0,
                                           n_picks, 1'b0));
            clear_trace_state();
        end

        if (made.size() > 0)
            made[made.size()-1].last = 1'b1;
        foreach (made[i])
            pending_results.push_back(made[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    task automatic check_result();
        pick_result_t want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d index %0d value %0d total %0d",
                   result_kind, pick_index, pick_value, pick_total);
            n_errors++;
        end
        else begin
            want = pending_results.pop_front();
            n_checked++;
            if (result_kind !== want.kind) begin
                $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                n_errors++;
            end
            if (pick_index !== want.at_index) begin
                $error("pick_index: expected %0d, actual %0d", want.at_index, pick_index);
                n_errors++;
            end
            if (pick_value !== want.level) begin
                $error("pick_value: expected %0d, actual %0d", want.level, pick_value);
                n_errors++;
            end
            if (pick_total !== want.total) begin
                $error("pick_total: expected %0d, actual %0d", want.total, pick_total);
                n_errors++;
            end
            if (used_fallback !== want.fallback) begin
                $error("used_fallback: expected %0d, actual %0d", want.fallback,
                       used_fallback);
                n_errors++;
            end
            if (last_of_run !== want.last) begin
                $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
                n_errors++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver stalls and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("envelope_peak_picker_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // write one register; the caller lowers cfg_write after the group
    task automatic write_reg(input logic [epp_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            epp_pkg::REG_THRESHOLD:       cfg_threshold    = data;
            epp_pkg::REG_SEARCH_START:    cfg_search_start = data;
            epp_pkg::REG_SEARCH_END:      cfg_search_end   = data;
            epp_pkg::REG_SPACING_WINDOW:  cfg_spacing      = data;
            epp_pkg::REG_REPLACE_WINDOW:  cfg_replace      = data;
            epp_pkg::REG_FALLBACK_ENABLE: cfg_fallback     = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [15:0] first_idx,
                                  input logic [15:0] last_idx, input logic [15:0] spacing,
                                  input logic [15:0] replace, input logic fallback);
        write_reg(epp_pkg::REG_THRESHOLD, thr);
        write_reg(epp_pkg::REG_SEARCH_START, first_idx);
        write_reg(epp_pkg::REG_SEARCH_END, last_idx);
        write_reg(epp_pkg::REG_SPACING_WINDOW, spacing);
        write_reg(epp_pkg::REG_REPLACE_WINDOW, replace);
        write_reg(epp_pkg::REG_FALLBACK_ENABLE, {15'd0, fallback});
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    // one sample transfer; valid stays high across back-to-back transfers
    task automatic send_sample(input logic [15:0] lvl, input logic eot);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid     <= 1'b1;
        ee_sample    <= lvl;
        end_of_trace <= eot;
        do @(posedge clk); while (!in_ready);
        predict_sample(lvl, eot);
        n_samples++;
        if (eot)
            n_traces++;
    endtask

    task automatic send_trace(input logic [15:0] levels [$]);
        foreach (levels[i])
            send_sample(levels[i], i == levels.size() - 1);
    endtask

    // block idle: in_valid low and every expected result delivered
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // envelope levels biased toward the threshold so that peaks are common
    function automatic logic [15:0] gen_level();
        int v;
        case ($urandom_range(0, 7))
            0, 1:    v = int'($urandom_range(0, 65535));
            2:       v = int'($urandom_range(0, 255));
            3:       v = $urandom_range(0, 1) ? 0 : 65535;
            default: v = int'(cfg_threshold) + int'($urandom_range(0, 3000)) - 800;
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    task automatic randomize_settings();
        logic [15:0] thr;
        logic [15:0] first_idx;
        logic [15:0] last_idx;
        logic [15:0] spacing;
        logic [15:0] replace;
        case ($urandom_range(0, 5))
            0:       thr = 16'd0;
            1:       thr = 16'hFFFF;
            2:       thr = 16'($urandom_range(0, 65535));
            default: thr = 16'($urandom_range(0, 4000));
        endcase
        case ($urandom_range(0, 5))
            0:       first_idx = 16'hFFFF;
            1:       first_idx = 16'd0;
            default: first_idx = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
            0:       last_idx = 16'hFFFF;
            1:       last_idx = 16'hFFFE;
            2:       last_idx = 16'($urandom_range(0, 8));
            default: last_idx = 16'($urandom_range(10, 60));
        endcase
        case ($urandom_range(0, 4))
            0:       spacing = 16'd0;
            1:       spacing = 16'hFFFF;
            default: spacing = 16'($urandom_range(0, 30));
        endcase
        case ($urandom_range(0, 4))
            0:       replace = 16'd0;
            1:       replace = 16'hFFFF;
            default: replace = 16'($urandom_range(0, 30));
        endcase
        apply_settings(thr, first_idx, last_idx, spacing, replace,
                       1'($urandom_range(0, 1)));
    endtask

    // whole traces of random length until at least n_items samples went in
    task automatic send_random_traces(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(25, 70))
                                              : int'($urandom_range(1, 20));
            for (int i = 0; i < len; i++)
                send_sample(gen_level(), i == len - 1);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset defaults: pick, replace, drop below half, new pick, edge samples
    task automatic test_picking_rules();
        send_trace('{16'hFFFF, 16'd0, 16'd2000, 16'd100, 16'd100, 16'd3000, 16'd10,
                     16'd10, 16'd1000, 16'd10, 16'd10, 16'd1600, 16'd10, 16'd10,
                     16'hFFFF, 16'hFFFF});
        settle();
    endtask

    // fallback with and without a window maximum, empty search window
    task automatic test_fallback_and_window();
        apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1);
        send_trace('{16'd9000, 16'd500, 16'd700, 16'd300});
        send_trace('{16'd0, 16'd0, 16'd0});
        send_trace('{16'd4321});
        settle();
        apply_settings(16'd0, 16'd5, 16'd2, 16'd20, 16'd10, 1'b1);
        send_trace('{16'd100, 16'd200, 16'd50, 16'd10});
        settle();
    endtask

    // random settings and traces under one traffic mix
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++) begin
            if (seg == 0 && idle_pct == 0)
                apply_settings(16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
            else
                randomize_settings();
            send_random_traces(n_items / 4);
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_threshold    = epp_pkg::THRESHOLD_RST;
        cfg_search_start = epp_pkg::SEARCH_START_RST;
        cfg_search_end   = epp_pkg::SEARCH_END_RST;
        cfg_spacing      = epp_pkg::SPACING_WINDOW_RST;
        cfg_replace      = epp_pkg::REPLACE_WINDOW_RST;
        cfg_fallback     = 1'b0;
        clear_trace_state();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_picking_rules();
        test_fallback_and_window();
        test_random_traffic(20, 69, 120);
        test_random_traffic(69, 20, 120);
        test_random_traffic(0, 0, 120);

        $display("covered %0d samples in %0d traces under %0d register settings",
                 n_samples, n_traces, n_settings);
        $display("checked %0d results across sender gaps and receiver stalls",
                 n_checked);
        if (n_errors == 0)
            $display("envelope_peak_picker_tb OK");
        else
            $display("envelope_peak_picker_tb NOT OK");
        $finish;
    end

endmodule
